### hw/rtl/pifht_pkg.sv
package pifht_pkg;

  localparam int unsigned COORD_WIDTH = 16;
  localparam int unsigned MAX_FIGURES = 16;
  localparam int unsigned NUM_W       = 7;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    FUNC_CIRCLE = 2'd0,
    FUNC_RECT   = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic {
    KIND_CIRCLE = 1'b0,
    KIND_RECT   = 1'b1
  } kind_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } cmd_op_e;

  typedef struct packed {
    func_e                   func;
    logic signed [COORD_WIDTH-1:0] coord_a;
    logic signed [COORD_WIDTH-1:0] coord_b;
    logic signed [COORD_WIDTH-1:0] coord_c;
    logic signed [COORD_WIDTH-1:0] coord_d;
  } in_item_t;

  typedef struct packed {
    logic             hit;
    logic [NUM_W-1:0] figure_number;
    logic             last;
  } out_item_t;

  // One table entry; rectangles hold a,b as the low corner and c,d as the high one.
  typedef struct packed {
    kind_e                         kind;
    logic signed [COORD_WIDTH-1:0] a;
    logic signed [COORD_WIDTH-1:0] b;
    logic signed [COORD_WIDTH-1:0] c;
    logic signed [COORD_WIDTH-1:0] d;
  } fig_t;

  // Query point travels in fig.a / fig.b.
  typedef struct packed {
    cmd_op_e op;
    fig_t    fig;
  } cmd_t;

endpackage

### hw/rtl/pifht_front.sv
module pifht_front (
  input  pifht_pkg::in_item_t in_item_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                full_i,
  output logic                push_o,
  output pifht_pkg::cmd_t     cmd_o
);

  logic keep;

  always_comb begin
    keep            = 1'b1;
    cmd_o.op        = pifht_pkg::OP_LOAD;
    cmd_o.fig.kind  = pifht_pkg::KIND_CIRCLE;
    cmd_o.fig.a     = in_item_i.coord_a;
    cmd_o.fig.b     = in_item_i.coord_b;
    cmd_o.fig.c     = in_item_i.coord_c;
    cmd_o.fig.d     = '0;
    unique case (in_item_i.func)
      pifht_pkg::FUNC_CIRCLE: begin
        cmd_o.op = pifht_pkg::OP_LOAD;
      end
      pifht_pkg::FUNC_RECT: begin
        // sort corners so the back end tests low < p < high
        cmd_o.fig.kind = pifht_pkg::KIND_RECT;
        if (in_item_i.coord_a <= in_item_i.coord_c) begin
          cmd_o.fig.a = in_item_i.coord_a;
          cmd_o.fig.c = in_item_i.coord_c;
        end else begin
          cmd_o.fig.a = in_item_i.coord_c;
          cmd_o.fig.c = in_item_i.coord_a;
        end
        if (in_item_i.coord_b <= in_item_i.coord_d) begin
          cmd_o.fig.b = in_item_i.coord_b;
          cmd_o.fig.d = in_item_i.coord_d;
        end else begin
          cmd_o.fig.b = in_item_i.coord_d;
          cmd_o.fig.d = in_item_i.coord_b;
        end
      end
      pifht_pkg::FUNC_QUERY: begin
        cmd_o.op = pifht_pkg::OP_QUERY;
      end
      pifht_pkg::FUNC_NONE: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i && keep;

endmodule

### hw/rtl/pifht_fifo.sv
module pifht_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pifht_pkg::cmd_t data_i,
  output logic            full_o,
  output logic            valid_o,
  output pifht_pkg::cmd_t data_o,
  input  logic            pop_i
);

  localparam int unsigned Depth = pifht_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;

  pifht_pkg::cmd_t entry_q [Depth];
  logic [PtrW:0]   wr_q, wr_d;
  logic [PtrW:0]   rd_q, rd_d;

  assign valid_o = (wr_q != rd_q);
  assign full_o  = (wr_q[PtrW-1:0] == rd_q[PtrW-1:0]) && (wr_q[PtrW] != rd_q[PtrW]);
  assign data_o  = entry_q[rd_q[PtrW-1:0]];

  assign wr_d = push_i ? wr_q + 1'b1 : wr_q;
  assign rd_d = pop_i  ? rd_q + 1'b1 : rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q[PtrW-1:0]] <= data_i;
    end
  end

endmodule

### hw/rtl/pifht_back.sv
module pifht_back #(
  parameter int unsigned MAX_FIGURES = pifht_pkg::MAX_FIGURES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  pifht_pkg::cmd_t      cmd_i,
  output logic                 cmd_pop_o,
  output logic                 out_valid_o,
  output pifht_pkg::out_item_t out_item_o,
  input  logic                 out_stall_i
);

  localparam int unsigned CW    = pifht_pkg::COORD_WIDTH;
  localparam int unsigned NW    = pifht_pkg::NUM_W;
  localparam int unsigned IdxW  = (MAX_FIGURES > 1) ? $clog2(MAX_FIGURES) : 1;
  localparam int unsigned CntW  = $clog2(MAX_FIGURES + 1);
  localparam int unsigned SqW   = 2 * (CW + 1);
  localparam int unsigned SumW  = SqW + 1;

  function automatic logic [CW:0] mag(input logic signed [CW:0] v);
    logic signed [CW:0] n;
    n = -v;
    return v[CW] ? $unsigned(n) : $unsigned(v);
  endfunction

  pifht_pkg::fig_t mem_q [MAX_FIGURES];
  pifht_pkg::fig_t rd_q;

  logic adv;
  logic out_valid_q, out_valid_d;
  assign adv = !out_valid_q || !out_stall_i;

  // issue / walk control
  logic            walk_q, walk_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            load_we;
  logic            iss_v, iss_fig;
  logic [CntW-1:0] iss_idx;
  logic signed [CW-1:0] px_q, py_q, iss_px, iss_py;

  always_comb begin
    iss_v     = 1'b0;
    iss_fig   = 1'b0;
    iss_idx   = idx_q;
    iss_px    = px_q;
    iss_py    = py_q;
    cmd_pop_o = 1'b0;
    load_we   = 1'b0;
    walk_d    = walk_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    if (adv) begin
      if (walk_q) begin
        iss_v = 1'b1;
        if (idx_q == cnt_q) begin
          walk_d = 1'b0;               // trailing end-of-query beat
        end else begin
          iss_fig = 1'b1;
          idx_d   = idx_q + 1'b1;
        end
      end else if (cmd_valid_i) begin
        cmd_pop_o = 1'b1;
        unique case (cmd_i.op)
          pifht_pkg::OP_LOAD: begin
            if (cnt_q != CntW'(MAX_FIGURES)) begin
              load_we = 1'b1;
              cnt_d   = cnt_q + 1'b1;
            end
          end
          pifht_pkg::OP_QUERY: begin
            iss_v  = 1'b1;
            iss_px = cmd_i.fig.a;
            iss_py = cmd_i.fig.b;
            if (cnt_q != '0) begin
              iss_fig = 1'b1;
              iss_idx = '0;
              idx_d   = CntW'(1);
              walk_d  = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // stage 1: table read
  logic            s1_v, s1_fig;
  logic [CntW-1:0] s1_idx;
  logic signed [CW-1:0] s1_px, s1_py;

  // stage 2: distances and rectangle test
  logic            s2_v, s2_fig, s2_rect_in;
  logic [CntW-1:0] s2_idx;
  pifht_pkg::kind_e s2_kind;
  logic [CW:0]     s2_dx, s2_dy, s2_r;
  logic [CW:0]     dx_d, dy_d, r_d;
  logic            rect_in_d;

  assign dx_d = mag($signed({s1_px[CW-1], s1_px}) - $signed({rd_q.a[CW-1], rd_q.a}));
  assign dy_d = mag($signed({s1_py[CW-1], s1_py}) - $signed({rd_q.b[CW-1], rd_q.b}));
  assign r_d  = mag($signed({rd_q.c[CW-1], rd_q.c}));
  assign rect_in_d = (s1_px > rd_q.a) && (s1_px < rd_q.c) &&
                     (s1_py > rd_q.b) && (s1_py < rd_q.d);

  // stage 3: squares
  logic            s3_v, s3_fig, s3_rect_in, s3_early;
  logic [CntW-1:0] s3_idx;
  pifht_pkg::kind_e s3_kind;
  logic [SqW-1:0]  s3_sqx, s3_sqy, s3_sqr;
  logic [SqW-1:0]  sqx_d, sqy_d, sqr_d;

  assign sqx_d = s2_dx * s2_dx;
  assign sqy_d = s2_dy * s2_dy;
  assign sqr_d = s2_r * s2_r;

  // result stage: one hit is held back until the next hit or the end beat
  logic            hit3;
  logic [NW-1:0]   num3;
  logic            pend_v_q, pend_v_d;
  logic [NW-1:0]   pend_num_q, pend_num_d;
  pifht_pkg::out_item_t out_q, out_d;

  assign num3 = NW'(s3_idx) + NW'(1);

  always_comb begin
    priority if (!s3_fig) begin
      hit3 = 1'b0;
    end else if (s3_kind == pifht_pkg::KIND_RECT) begin
      hit3 = s3_rect_in;
    end else begin
      hit3 = !s3_early && ((SumW'(s3_sqx) + SumW'(s3_sqy)) < SumW'(s3_sqr));
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    pend_v_d    = pend_v_q;
    pend_num_d  = pend_num_q;
    if (adv && s3_v) begin
      if (s3_fig) begin
        if (hit3) begin
          if (pend_v_q) begin
            out_valid_d       = 1'b1;
            out_d.hit           = 1'b1;
            out_d.figure_number = pend_num_q;
            out_d.last          = 1'b0;
          end
          pend_v_d   = 1'b1;
          pend_num_d = num3;
        end
      end else begin
        out_valid_d         = 1'b1;
        out_d.hit           = pend_v_q;
        out_d.figure_number = pend_v_q ? pend_num_q : '0;
        out_d.last          = 1'b1;
        pend_v_d            = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q      <= 1'b0;
      idx_q       <= '0;
      cnt_q       <= '0;
      s1_v        <= 1'b0;
      s2_v        <= 1'b0;
      s3_v        <= 1'b0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      walk_q      <= walk_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
      if (adv) begin
        s1_v <= iss_v;
        s2_v <= s1_v;
        s3_v <= s2_v;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      mem_q[cnt_q[IdxW-1:0]] <= cmd_i.fig;
    end
    pend_num_q <= pend_num_d;
    out_q      <= out_d;
    if (adv) begin
      rd_q       <= mem_q[iss_idx[IdxW-1:0]];
      px_q       <= iss_px;
      py_q       <= iss_py;
      s1_fig     <= iss_fig;
      s1_idx     <= iss_idx;
      s1_px      <= iss_px;
      s1_py      <= iss_py;
      s2_fig     <= s1_fig;
      s2_idx     <= s1_idx;
      s2_kind    <= rd_q.kind;
      s2_rect_in <= rect_in_d;
      s2_dx      <= dx_d;
      s2_dy      <= dy_d;
      s2_r       <= r_d;
      s3_fig     <= s2_fig;
      s3_idx     <= s2_idx;
      s3_kind    <= s2_kind;
      s3_rect_in <= s2_rect_in;
      s3_early   <= (s2_dx >= s2_r) || (s2_dy >= s2_r);
      s3_sqx     <= sqx_d;
      s3_sqy     <= sqy_d;
      s3_sqr     <= sqr_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### hw/rtl/point_in_figures_hit_test.sv
// Hit test of a point against a table of circles and axis-aligned rectangles.
// Input channel (in_valid_i / in_stall_o, in_item_i): func selects load circle,
// load rectangle or query point; coordinates are signed Q12.4. Func code 3 is
// dropped, as is a load into a full table of MAX_FIGURES entries.
// Output channel (out_valid_o / out_stall_i, out_item_o): a query returns one
// beat per containing figure in table order (1-based figure_number), or one
// beat with hit=0 when none contains the point; last marks the final beat.
// Loads return nothing.
// The back end pops a load and stores it; a query walks the N figures stored,
// reading one table entry per cycle while the output is not stalled, then
// issues one end beat. No new command is popped during the walk, but a
// four-entry command queue lets inputs be taken while a query walks.
// Results pass the table-read, distance, square and result registers; a
// hit beat leaves once the next hit or the end is known.
// Reset empties the table and the queue; table contents are not cleared.
// A stalled output holds its beat and freezes the walk pipeline; the queue
// then fills and in_stall_o rises.
module point_in_figures_hit_test #(
  parameter int unsigned MAX_FIGURES = pifht_pkg::MAX_FIGURES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pifht_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pifht_pkg::out_item_t out_item_o
);

  logic            push, full, cmd_valid, cmd_pop;
  pifht_pkg::cmd_t cmd_in, cmd_out;

  pifht_front u_front (
    .in_item_i  (in_item_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  pifht_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .valid_o (cmd_valid),
    .data_o  (cmd_out),
    .pop_i   (cmd_pop)
  );

  pifht_back #(
    .MAX_FIGURES (MAX_FIGURES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

endmodule

### tb/sv/point_in_figures_hit_test_tb.sv
module point_in_figures_hit_test_tb;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = pifht_pkg::MAX_FIGURES + 12;
  localparam int unsigned LONG_HOLD    = 200;

  typedef logic signed [pifht_pkg::COORD_WIDTH-1:0] coord_t;

  // Mirror of the figure table; predicts the hit beats of every query.
  class hit_predictor;
    pifht_pkg::fig_t      figures[pifht_pkg::MAX_FIGURES];
    int unsigned          stored;
    pifht_pkg::out_item_t hits_due[$];
    int unsigned          mismatches;

    function new();
      stored     = 0;
      mismatches = 0;
    endfunction

    function bit contains(pifht_pkg::fig_t f, longint px, longint py);
      longint dx, dy, r;
      if (f.kind == pifht_pkg::KIND_CIRCLE) begin
        dx = px - longint'(f.a);
        dy = py - longint'(f.b);
        r  = longint'(f.c);
        return dx * dx + dy * dy < r * r;
      end
      return px > longint'(f.a) && px < longint'(f.c) &&
             py > longint'(f.b) && py < longint'(f.d);
    endfunction

    function void take_command(pifht_pkg::in_item_t it);
      pifht_pkg::fig_t      f;
      pifht_pkg::out_item_t held;
      bit                   any;
      case (it.func)
        pifht_pkg::FUNC_CIRCLE, pifht_pkg::FUNC_RECT: begin
          // loads into a full table are dropped
          if (stored < pifht_pkg::MAX_FIGURES) begin
            if (it.func == pifht_pkg::FUNC_CIRCLE) begin
              f.kind = pifht_pkg::KIND_CIRCLE;
              f.a    = it.coord_a;
              f.b    = it.coord_b;
              f.c    = it.coord_c;
              f.d    = '0;
            end else begin
              f.kind = pifht_pkg::KIND_RECT;
              f.a    = (it.coord_a <= it.coord_c) ? it.coord_a : it.coord_c;
              f.c    = (it.coord_a <= it.coord_c) ? it.coord_c : it.coord_a;
              f.b    = (it.coord_b <= it.coord_d) ? it.coord_b : it.coord_d;
              f.d    = (it.coord_b <= it.coord_d) ? it.coord_d : it.coord_b;
            end
            figures[stored] = f;
            stored++;
          end
        end
        pifht_pkg::FUNC_QUERY: begin
          any = 1'b0;
          for (int i = 0; i < stored; i++) begin
            if (contains(figures[i], it.coord_a, it.coord_b)) begin
              if (any) hits_due = {hits_due, held};
              held.hit           = 1'b1;
              held.figure_number = pifht_pkg::NUM_W'(i + 1);
              held.last          = 1'b0;
              any                = 1'b1;
            end
          end
          if (!any) begin
            held.hit           = 1'b0;
            held.figure_number = '0;
          end
          held.last = 1'b1;
          hits_due = {hits_due, held};
        end
        default: ;
      endcase
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_beat(pifht_pkg::out_item_t got);
      pifht_pkg::out_item_t want;
      if (hits_due.size() == 0) begin
        flag($sformatf("unexpected beat hit=%0d fig=%0d last=%0d",
                       got.hit, got.figure_number, got.last));
        return;
      end
      want = hits_due.pop_front();
      if (got.hit !== want.hit || got.figure_number !== want.figure_number ||
          got.last !== want.last)
        flag($sformatf("expected hit=%0d fig=%0d last=%0d, got hit=%0d fig=%0d last=%0d",
                       want.hit, want.figure_number, want.last,
                       got.hit, got.figure_number, got.last));
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  pifht_pkg::in_item_t  in_item_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  pifht_pkg::out_item_t out_item_o;

  hit_predictor         tracker;
  pifht_pkg::in_item_t  directed_q[$];
  bit                   calm     = 1'b0;
  int                   hold_req = 0;
  int unsigned          cycles   = 0;

  point_in_figures_hit_test dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("point_in_figures_hit_test_tb failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o && !out_stall_i) tracker.check_beat(out_item_o);
  end

  // Output side: short random stalls, plus one long hold on request.
  initial begin : recv_side
    int stall_run;
    stall_run = 0;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req != 0) begin
        stall_run = hold_req;
        hold_req  = 0;
      end else if (stall_run == 0 && !calm && $urandom_range(0, 5) == 0) begin
        stall_run = $urandom_range(1, 4);
      end
      out_stall_i <= (stall_run != 0);
      if (stall_run != 0) stall_run--;
    end
  end

  function automatic coord_t near_coord(int span);
    if ($urandom_range(0, 7) == 0) return coord_t'($urandom());
    return coord_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic pifht_pkg::in_item_t directed_item(pifht_pkg::func_e f,
                                                        int a, int b, int c, int d);
    pifht_pkg::in_item_t it;
    it.func    = f;
    it.coord_a = coord_t'(a);
    it.coord_b = coord_t'(b);
    it.coord_c = coord_t'(c);
    it.coord_d = coord_t'(d);
    return it;
  endfunction

  function automatic void add_directed(pifht_pkg::func_e f, int a, int b, int c, int d);
    directed_q = {directed_q, directed_item(f, a, b, c, d)};
  endfunction

  function automatic pifht_pkg::in_item_t noise_item();
    pifht_pkg::in_item_t it;
    it.func    = pifht_pkg::FUNC_NONE;
    it.coord_a = coord_t'($urandom());
    it.coord_b = coord_t'($urandom());
    it.coord_c = coord_t'($urandom());
    it.coord_d = coord_t'($urandom());
    return it;
  endfunction

  // Figures cluster around the origin so queries tend to hit several.
  function automatic pifht_pkg::in_item_t rand_load();
    pifht_pkg::in_item_t it;
    if ($urandom_range(0, 1) == 1) it.func = pifht_pkg::FUNC_RECT;
    else it.func = pifht_pkg::FUNC_CIRCLE;
    it.coord_a = near_coord(2000);
    it.coord_b = near_coord(2000);
    it.coord_c = near_coord(3000);
    it.coord_d = near_coord(3000);
    return it;
  endfunction

  function automatic pifht_pkg::in_item_t rand_query();
    pifht_pkg::in_item_t it;
    pifht_pkg::fig_t     f;
    longint              cx, cy, hx, hy;
    int                  sel;
    it.func    = pifht_pkg::FUNC_QUERY;
    it.coord_a = near_coord(3000);
    it.coord_b = near_coord(3000);
    it.coord_c = coord_t'($urandom());
    it.coord_d = coord_t'($urandom());
    sel = $urandom_range(0, 9);
    if (tracker.stored != 0 && sel >= 3) begin
      f = tracker.figures[$urandom_range(0, tracker.stored - 1)];
      if (f.kind == pifht_pkg::KIND_CIRCLE) begin
        cx = longint'(f.a);
        cy = longint'(f.b);
        hx = (f.c < 0) ? -longint'(f.c) : longint'(f.c);
        hy = hx;
      end else begin
        cx = (longint'(f.a) + longint'(f.c)) / 2;
        cy = (longint'(f.b) + longint'(f.d)) / 2;
        hx = (longint'(f.c) - longint'(f.a)) / 2;
        hy = (longint'(f.d) - longint'(f.b)) / 2;
      end
      if (sel < 5) begin
        // exactly on the outline: strict tests must reject it
        if ($urandom_range(0, 1) == 1) begin
          it.coord_a = coord_t'((f.kind == pifht_pkg::KIND_CIRCLE) ? cx + hx
                                                                  : longint'(f.c));
          it.coord_b = coord_t'(cy);
        end else begin
          it.coord_a = coord_t'(cx);
          it.coord_b = coord_t'((f.kind == pifht_pkg::KIND_CIRCLE) ? cy - hy
                                                                  : longint'(f.b));
        end
      end else begin
        it.coord_a = coord_t'(cx + longint'($urandom_range(0, int'(2 * hx))) - hx);
        it.coord_b = coord_t'(cy + longint'($urandom_range(0, int'(2 * hy))) - hy);
      end
    end
    return it;
  endfunction

  task automatic send_beat(pifht_pkg::in_item_t it);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_command(it);
  endtask

  initial begin : send_side
    int pick;
    tracker = new();
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_item_i  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, unused code, negative radius, swapped corners, outlines, extremes
    add_directed(pifht_pkg::FUNC_QUERY, 0, 0, 0, 0);
    add_directed(pifht_pkg::FUNC_NONE, 32767, -32768, 32767, -32768);
    add_directed(pifht_pkg::FUNC_CIRCLE, 0, 0, -160, 32767);
    add_directed(pifht_pkg::FUNC_RECT, 320, 320, -320, -320);
    add_directed(pifht_pkg::FUNC_QUERY, 0, 0, -1, -1);
    add_directed(pifht_pkg::FUNC_QUERY, 160, 0, 0, 0);
    add_directed(pifht_pkg::FUNC_QUERY, 0, -160, 0, 0);
    add_directed(pifht_pkg::FUNC_QUERY, 320, 0, 0, 0);
    add_directed(pifht_pkg::FUNC_QUERY, 0, 319, 0, 0);
    add_directed(pifht_pkg::FUNC_CIRCLE, 5, 5, 0, -1);
    add_directed(pifht_pkg::FUNC_QUERY, 5, 5, 0, 0);
    add_directed(pifht_pkg::FUNC_CIRCLE, -32768, -32768, 32767, 0);
    add_directed(pifht_pkg::FUNC_RECT, 32767, -32768, -32768, 32767);
    add_directed(pifht_pkg::FUNC_QUERY, -32768, -32768, 0, 0);
    add_directed(pifht_pkg::FUNC_QUERY, 32767, 32767, 0, 0);
    add_directed(pifht_pkg::FUNC_QUERY, -32767, -32767, 0, 0);
    add_directed(pifht_pkg::FUNC_QUERY, -32768, 32767, 32767, -32768);
    add_directed(pifht_pkg::FUNC_NONE, -1, -1, -1, -1);
    foreach (directed_q[i]) send_beat(directed_q[i]);

    // fill the table while querying it
    for (int n = 0; n < 60; n++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) send_beat(noise_item());
      else if (pick < 10 && tracker.stored < pifht_pkg::MAX_FIGURES) send_beat(rand_load());
      else send_beat(rand_query());
    end

    // long output hold while inputs keep coming; loads now land on a full table
    hold_req = LONG_HOLD;
    for (int n = 0; n < 200; n++) begin
      if (n == 160) calm = 1'b1;
      pick = $urandom_range(0, 19);
      if (pick == 0) send_beat(noise_item());
      else if (pick < 3) send_beat(rand_load());
      else send_beat(rand_query());
    end
    in_valid_i <= 1'b0;

    while (tracker.hits_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.hits_due.size() == 0) begin
      $display("point_in_figures_hit_test_tb passed");
    end else begin
      $display("point_in_figures_hit_test_tb failed");
    end
    $finish;
  end

endmodule
